### rtl/core/edpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpm_pkg: shared types and constants of the encoder distance move controller
// Word formats, configuration record, operation codes and the derived widths
// of the position loop datapath.
// ----------------------------------------------------------------------------
package edpm_pkg;

  localparam int POSITION_WIDTH     = 24;
  localparam int GAIN_FRACTION_BITS = 8;

  localparam int TARGET_W = 24;
  localparam int GAIN_W   = 16;
  localparam int BAND_W   = 16;
  localparam int LIMIT_W  = 7;
  localparam int DRIVE_W  = 8;

  // Error, derivative and integral widths.
  localparam int ERR_W = ((POSITION_WIDTH > TARGET_W) ? POSITION_WIDTH : TARGET_W) + 1;
  localparam int DER_W = ERR_W + 1;
  localparam int INT_W = 10;

  // Product and sum widths (gains are unsigned, extended by one sign bit).
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + INT_W;
  localparam int PROD_D_W = GAIN_W + 1 + DER_W;
  localparam int SUM_W    = PROD_D_W + 1;
  localparam int QUO_W    = SUM_W - GAIN_FRACTION_BITS;

  localparam int INTEGRAL_WINDOW = 100;
  localparam int INTEGRAL_LIMIT  = 500;
  localparam int DRIVE_MAX       = 100;
  localparam int SETTLE_MAX      = 3;
  localparam int SETTLE_W        = 2;
  localparam int STALL_W         = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_RUNNING = 2'd0,
    CAUSE_SETTLED = 2'd1,
    CAUSE_STALLED = 2'd2
  } cause_t;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_SPEED_LIMIT    = 3'd3,
    REG_TARGET_DEGREES = 3'd4,
    REG_SETTLE_BAND    = 3'd5,
    REG_PROGRESS_BAND  = 3'd6,
    REG_TIMEOUT_TICKS  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic                               req_type;
    logic signed [POSITION_WIDTH-1:0]   left_position;
    logic signed [POSITION_WIDTH-1:0]   right_position;
  } req_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      done_res;
    logic [1:0]                end_cause;
  } rsp_t;

  typedef struct packed {
    logic [GAIN_W-1:0]          gain_p;
    logic [GAIN_W-1:0]          gain_i;
    logic [GAIN_W-1:0]          gain_d;
    logic [LIMIT_W-1:0]         speed_limit;
    logic signed [TARGET_W-1:0] target_degrees;
    logic [BAND_W-1:0]          settle_band;
    logic [BAND_W-1:0]          progress_band;
    logic [STALL_W-1:0]         timeout_ticks;
  } cfg_t;

  // Operation handed from the front end to the loop back end.
  typedef struct packed {
    logic                    start;
    logic signed [ERR_W-1:0] err;
  } op_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

### rtl/core/edpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpm_front: request intake and position error
// Accepts request words, keeps the encoder baseline, and turns each sample
// into a signed position error for the loop back end.
// ----------------------------------------------------------------------------
module edpm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  edpm_pkg::req_t         req,
  input  edpm_pkg::cfg_t         cfg,
  input  edpm_pkg::queue_status_t qstat,
  output logic                   push,
  output edpm_pkg::op_t          push_op
);

  logic                                   f_valid;
  logic                                   f_start;
  logic signed [edpm_pkg::POSITION_WIDTH-1:0] f_dl;
  logic signed [edpm_pkg::POSITION_WIDTH-1:0] f_dr;
  logic signed [edpm_pkg::POSITION_WIDTH-1:0] baseline_left;
  logic signed [edpm_pkg::POSITION_WIDTH-1:0] baseline_right;
  logic                                   accept;
  logic signed [edpm_pkg::POSITION_WIDTH:0]   delta_sum;
  logic signed [edpm_pkg::POSITION_WIDTH-1:0] travelled;

  assign req_stall = f_valid & qstat.full;
  assign accept    = req_valid & ~req_stall;
  assign push      = f_valid & ~qstat.full;

  // Average of the two wrapped deltas, rounded toward minus infinity.
  assign delta_sum = (edpm_pkg::POSITION_WIDTH + 1)'(f_dl) + (edpm_pkg::POSITION_WIDTH + 1)'(f_dr);
  assign travelled = delta_sum[edpm_pkg::POSITION_WIDTH:1];

  always_comb begin
    push_op.start = f_start;
    push_op.err   = edpm_pkg::ERR_W'(cfg.target_degrees) - edpm_pkg::ERR_W'(travelled);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid        <= 1'b0;
      baseline_left  <= '0;
      baseline_right <= '0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
      end else if (push) begin
        f_valid <= 1'b0;
      end
      if (accept && req.req_type == edpm_pkg::REQ_START) begin
        baseline_left  <= req.left_position;
        baseline_right <= req.right_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_start <= (req.req_type == edpm_pkg::REQ_START);
      f_dl    <= req.left_position - baseline_left;
      f_dr    <= req.right_position - baseline_right;
    end
  end

endmodule

### rtl/core/edpm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpm_queue: operation queue between front and back end
// A small FIFO of loop operations so that either side can stall on its own.
// ----------------------------------------------------------------------------
module edpm_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  edpm_pkg::op_t           push_op,
  input  logic                    pop,
  output edpm_pkg::op_t           head,
  output edpm_pkg::queue_status_t qstat
);

  edpm_pkg::op_t                entries [edpm_pkg::QUEUE_DEPTH];
  logic [edpm_pkg::QPTR_W-1:0]  wr_ptr;
  logic [edpm_pkg::QPTR_W-1:0]  rd_ptr;
  logic [edpm_pkg::QCNT_W-1:0]  count;

  localparam logic [edpm_pkg::QPTR_W-1:0] LastPtr = edpm_pkg::QPTR_W'(edpm_pkg::QUEUE_DEPTH - 1);
  localparam logic [edpm_pkg::QCNT_W-1:0] FullCnt = edpm_pkg::QCNT_W'(edpm_pkg::QUEUE_DEPTH);

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == FullCnt);
  assign qstat.valid = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full || pop)
    else $error("operation queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> qstat.valid)
    else $error("operation queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("operation queue count out of range");

endmodule

### rtl/core/edpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpm_back: loop state, PID products and drive saturation
// Stage one updates integral, derivative and termination counters; stage two
// forms the three gain products; the output stage scales and saturates.
// ----------------------------------------------------------------------------
module edpm_back (
  input  logic                    clk,
  input  logic                    rst,
  input  edpm_pkg::cfg_t          cfg,
  input  edpm_pkg::queue_status_t qstat,
  input  edpm_pkg::op_t           head,
  output logic                    pop,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output edpm_pkg::rsp_t          rsp
);

  localparam int EW = edpm_pkg::ERR_W;
  localparam int IW = edpm_pkg::INT_W;
  localparam int FB = edpm_pkg::GAIN_FRACTION_BITS;

  // Loop state.
  logic signed [EW-1:0]                 previous_error;
  logic signed [IW-1:0]                 integral_sum;
  logic [edpm_pkg::SETTLE_W-1:0]        settle_count;
  logic [edpm_pkg::STALL_W-1:0]         stall_count;
  logic                                 finished;
  edpm_pkg::cause_t                     end_code;

  // Stage one.
  logic                                 s1_valid;
  logic                                 s1_pid;
  logic                                 s1_done;
  edpm_pkg::cause_t                     s1_cause;
  logic signed [EW-1:0]                 s1_err;
  logic signed [IW-1:0]                 s1_int;
  logic signed [edpm_pkg::DER_W-1:0]    s1_der;

  // Stage two.
  logic                                 s2_valid;
  logic                                 s2_pid;
  logic                                 s2_done;
  edpm_pkg::cause_t                     s2_cause;
  logic signed [edpm_pkg::PROD_P_W-1:0] s2_pp;
  logic signed [edpm_pkg::PROD_I_W-1:0] s2_pi;
  logic signed [edpm_pkg::PROD_D_W-1:0] s2_pd;

  logic out_ok, s2_ready, s1_ready;

  // Sample arithmetic on the queue head.
  logic [EW-1:0]                        aerr;
  logic signed [IW:0]                   int_acc;
  logic signed [IW-1:0]                 int_next;
  logic signed [edpm_pkg::DER_W-1:0]    der;
  logic [edpm_pkg::SETTLE_W-1:0]        settle_next;
  logic [edpm_pkg::STALL_W-1:0]         stall_next;
  edpm_pkg::cause_t                     cause_next;

  // Output arithmetic.
  logic signed [edpm_pkg::GAIN_W:0]     gp_s, gi_s, gd_s;
  logic signed [edpm_pkg::SUM_W-1:0]    pid_sum;
  logic signed [edpm_pkg::SUM_W-1:0]    pid_adj;
  logic signed [edpm_pkg::QUO_W-1:0]    quo;
  logic [edpm_pkg::LIMIT_W-1:0]         lim;
  logic signed [edpm_pkg::QUO_W-1:0]    lim_pos, lim_neg;
  logic signed [edpm_pkg::DRIVE_W-1:0]  drive_sat;

  localparam logic [edpm_pkg::STALL_W-1:0]  StallMax  = '1;
  localparam logic [edpm_pkg::SETTLE_W-1:0] SettleMax = edpm_pkg::SETTLE_W'(edpm_pkg::SETTLE_MAX);

  assign out_ok   = ~rsp_valid | ~rsp_stall;
  assign s2_ready = ~s2_valid | out_ok;
  assign s1_ready = ~s1_valid | s2_ready;
  assign pop      = qstat.valid & s1_ready;

  always_comb begin
    aerr    = head.err[EW-1] ? EW'(-head.err) : EW'(head.err);
    int_acc = (IW + 1)'(integral_sum) + head.err[IW:0];
    if (aerr > EW'(edpm_pkg::INTEGRAL_WINDOW) || head.err == '0) begin
      int_next = '0;
    end else if (int_acc > (IW + 1)'(edpm_pkg::INTEGRAL_LIMIT)) begin
      int_next = IW'(edpm_pkg::INTEGRAL_LIMIT);
    end else if (int_acc < -(IW + 1)'(edpm_pkg::INTEGRAL_LIMIT)) begin
      int_next = -IW'(edpm_pkg::INTEGRAL_LIMIT);
    end else begin
      int_next = int_acc[IW-1:0];
    end
    der = edpm_pkg::DER_W'(head.err) - edpm_pkg::DER_W'(previous_error);

    if (aerr < EW'(cfg.settle_band)) begin
      settle_next = (settle_count == SettleMax) ? settle_count : settle_count + 1'b1;
    end else begin
      settle_next = '0;
    end
    if (aerr > EW'(cfg.progress_band)) begin
      stall_next = '0;
    end else begin
      stall_next = (stall_count == StallMax) ? stall_count : stall_count + 1'b1;
    end

    if (settle_next > edpm_pkg::SETTLE_W'(1)) begin
      cause_next = edpm_pkg::CAUSE_SETTLED;
    end else if (stall_next > cfg.timeout_ticks) begin
      cause_next = edpm_pkg::CAUSE_STALLED;
    end else begin
      cause_next = edpm_pkg::CAUSE_RUNNING;
    end
  end

  // Loop state and stage one registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
      settle_count   <= '0;
      stall_count    <= '0;
      finished       <= 1'b1;
      end_code       <= edpm_pkg::CAUSE_RUNNING;
      s1_valid       <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop;
      end
      if (pop) begin
        if (head.start) begin
          previous_error <= '0;
          integral_sum   <= '0;
          settle_count   <= '0;
          stall_count    <= '0;
          finished       <= 1'b0;
          end_code       <= edpm_pkg::CAUSE_RUNNING;
        end else if (!finished) begin
          previous_error <= head.err;
          integral_sum   <= int_next;
          settle_count   <= settle_next;
          stall_count    <= stall_next;
          if (cause_next != edpm_pkg::CAUSE_RUNNING) begin
            finished <= 1'b1;
            end_code <= cause_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_err <= head.err;
      s1_int <= int_next;
      s1_der <= der;
      if (head.start) begin
        s1_pid   <= 1'b0;
        s1_done  <= 1'b0;
        s1_cause <= edpm_pkg::CAUSE_RUNNING;
      end else if (finished) begin
        s1_pid   <= 1'b0;
        s1_done  <= 1'b1;
        s1_cause <= end_code;
      end else begin
        s1_pid   <= (cause_next == edpm_pkg::CAUSE_RUNNING);
        s1_done  <= (cause_next != edpm_pkg::CAUSE_RUNNING);
        s1_cause <= cause_next;
      end
    end
  end

  // Stage two: gain products.
  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gi_s = $signed({1'b0, cfg.gain_i});
  assign gd_s = $signed({1'b0, cfg.gain_d});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_pid   <= s1_pid;
      s2_done  <= s1_done;
      s2_cause <= s1_cause;
      s2_pp    <= gp_s * s1_err;
      s2_pi    <= gi_s * s1_int;
      s2_pd    <= gd_s * s1_der;
    end
  end

  // Output stage: scale toward zero, then saturate to the speed limit.
  always_comb begin
    pid_sum = edpm_pkg::SUM_W'(s2_pp) + edpm_pkg::SUM_W'(s2_pi) + edpm_pkg::SUM_W'(s2_pd);
    pid_adj = pid_sum + (pid_sum[edpm_pkg::SUM_W-1] ? edpm_pkg::SUM_W'((2 ** FB) - 1)
                                                    : edpm_pkg::SUM_W'(0));
    quo     = pid_adj[edpm_pkg::SUM_W-1:FB];
    lim     = (cfg.speed_limit > edpm_pkg::LIMIT_W'(edpm_pkg::DRIVE_MAX))
            ? edpm_pkg::LIMIT_W'(edpm_pkg::DRIVE_MAX) : cfg.speed_limit;
    lim_pos = edpm_pkg::QUO_W'({1'b0, lim});
    lim_neg = -lim_pos;
    if (!s2_pid) begin
      drive_sat = '0;
    end else if (quo > lim_pos) begin
      drive_sat = edpm_pkg::DRIVE_W'(lim_pos);
    end else if (quo < lim_neg) begin
      drive_sat = edpm_pkg::DRIVE_W'(lim_neg);
    end else begin
      drive_sat = quo[edpm_pkg::DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_ok) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ok) begin
      rsp.drive     <= drive_sat;
      rsp.done_res  <= s2_done;
      rsp.end_cause <= s2_cause;
    end
  end

  a_integral_clamped: assert property (@(posedge clk) disable iff (rst)
      integral_sum <= IW'(edpm_pkg::INTEGRAL_LIMIT) && integral_sum >= -IW'(edpm_pkg::INTEGRAL_LIMIT))
    else $error("integral outside its clamp");
  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
      pop && !head.start && finished |=> $stable(integral_sum) && $stable(previous_error) && finished)
    else $error("loop state changed by a sample after the move ended");
  a_running_no_cause: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp.done_res |-> rsp.end_cause == edpm_pkg::CAUSE_RUNNING)
    else $error("running result carries an end cause");

endmodule

### rtl/core/encoder_distance_pid_move.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_distance_pid_move: encoder distance PID move controller
// Drives a two-sided base to a target travel from left and right encoder
// positions, with integral clamp, speed saturation and settle/stall ending.
// ----------------------------------------------------------------------------
// Usage:
//   Software programs gains, speed limit, target and bands over the APB-style
//   port while the block is idle; pready is always high and reads return the
//   stored register value. A request word with req_type 0 starts a move and
//   latches both encoder positions as the baseline; a request word with
//   req_type 1 is one control tick. Every request word yields exactly one
//   response word carrying drive, done_res and end_cause.
//   A word is taken on a rising edge with valid high and stall low.
//   A word passes the front-end register, the queue, both back-end stages and
//   the response register. The block takes one request word per cycle unless
//   the receiver stalls: the only recurrence is the update of integral,
//   previous error and the termination counters in the first back-end stage;
//   the gain products and the output scaling are pipelined behind it.
//   Reset empties the pipeline, restores every setting to its default and
//   leaves the controller finished with end cause zero until a start arrives.
//   When the receiver stalls, the response word holds, the back-end stages
//   and the two-entry queue fill, and req_stall rises once the front-end
//   register cannot hand its word on.
// ----------------------------------------------------------------------------
module encoder_distance_pid_move (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [edpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [edpm_pkg::DATA_W-1:0]  pwdata,
  output logic [edpm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // Request channel.
  input  logic                         req_valid,
  output logic                         req_stall,
  input  edpm_pkg::req_t               req,
  // Response channel.
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output edpm_pkg::rsp_t               rsp
);

  edpm_pkg::cfg_t          cfg;
  edpm_pkg::reg_index_t    reg_sel;
  edpm_pkg::queue_status_t qstat;
  edpm_pkg::op_t           push_op;
  edpm_pkg::op_t           head;
  logic                    push;
  logic                    pop;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_sel   = edpm_pkg::reg_index_t'(paddr[4:2]);

  // Register file. Writes take the low bits of the data word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= 16'd18;
      cfg.gain_i         <= 16'd5;
      cfg.gain_d         <= 16'd102;
      cfg.speed_limit    <= 7'd100;
      cfg.target_degrees <= '0;
      cfg.settle_band    <= '0;
      cfg.progress_band  <= '0;
      cfg.timeout_ticks  <= 16'd50;
    end else if (cfg_write) begin
      case (reg_sel)
        edpm_pkg::REG_GAIN_P:         cfg.gain_p         <= pwdata[edpm_pkg::GAIN_W-1:0];
        edpm_pkg::REG_GAIN_I:         cfg.gain_i         <= pwdata[edpm_pkg::GAIN_W-1:0];
        edpm_pkg::REG_GAIN_D:         cfg.gain_d         <= pwdata[edpm_pkg::GAIN_W-1:0];
        edpm_pkg::REG_SPEED_LIMIT:    cfg.speed_limit    <= pwdata[edpm_pkg::LIMIT_W-1:0];
        edpm_pkg::REG_TARGET_DEGREES: cfg.target_degrees <= pwdata[edpm_pkg::TARGET_W-1:0];
        edpm_pkg::REG_SETTLE_BAND:    cfg.settle_band    <= pwdata[edpm_pkg::BAND_W-1:0];
        edpm_pkg::REG_PROGRESS_BAND:  cfg.progress_band  <= pwdata[edpm_pkg::BAND_W-1:0];
        edpm_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[edpm_pkg::STALL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back; the target is returned sign-extended.
  always_comb begin
    case (reg_sel)
      edpm_pkg::REG_GAIN_P:         prdata = edpm_pkg::DATA_W'(cfg.gain_p);
      edpm_pkg::REG_GAIN_I:         prdata = edpm_pkg::DATA_W'(cfg.gain_i);
      edpm_pkg::REG_GAIN_D:         prdata = edpm_pkg::DATA_W'(cfg.gain_d);
      edpm_pkg::REG_SPEED_LIMIT:    prdata = edpm_pkg::DATA_W'(cfg.speed_limit);
      edpm_pkg::REG_TARGET_DEGREES: prdata = edpm_pkg::DATA_W'(cfg.target_degrees);
      edpm_pkg::REG_SETTLE_BAND:    prdata = edpm_pkg::DATA_W'(cfg.settle_band);
      edpm_pkg::REG_PROGRESS_BAND:  prdata = edpm_pkg::DATA_W'(cfg.progress_band);
      edpm_pkg::REG_TIMEOUT_TICKS:  prdata = edpm_pkg::DATA_W'(cfg.timeout_ticks);
      default:                      prdata = '0;
    endcase
  end

  // Front end: baseline and position error.
  edpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg       (cfg),
    .qstat     (qstat),
    .push      (push),
    .push_op   (push_op)
  );

  // Decoupling queue.
  edpm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .qstat   (qstat)
  );

  // Back end: loop state, PID and output register.
  edpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### verif/edpm_move_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpm_move_checker: response checker of the encoder distance move controller
// Follows the configuration writes and every accepted request word, predicts
// the response word of each one and compares it with what the block returns.
// ----------------------------------------------------------------------------
module edpm_move_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [edpm_pkg::ADDR_W-1:0] paddr,
  input  logic [edpm_pkg::DATA_W-1:0] pwdata,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  edpm_pkg::req_t              req,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  edpm_pkg::rsp_t              rsp,
  output int                          mismatches,
  output int                          words_due
);

  import edpm_pkg::*;

  cfg_t                             cfg;
  logic signed [POSITION_WIDTH-1:0] base_left;
  logic signed [POSITION_WIDTH-1:0] base_right;
  logic signed [ERR_W-1:0]          last_error;
  logic signed [INT_W-1:0]          integ;
  logic [SETTLE_W-1:0]              settle_run;
  logic [STALL_W-1:0]               stall_run;
  logic                             move_over;
  cause_t                           last_cause;
  rsp_t                             due_words[$];

  // Loop update for one request word; returns the response word it causes.
  function automatic rsp_t move_step(input req_t w);
    logic signed [POSITION_WIDTH-1:0] dl;
    logic signed [POSITION_WIDTH-1:0] dr;
    longint travel, err, mag, der, acc, pid, quo, lim;
    cause_t cause;
    rsp_t   r;
    r = '0;
    cause = CAUSE_RUNNING;
    if (w.req_type == REQ_START) begin
      base_left  = w.left_position;
      base_right = w.right_position;
      last_error = '0;
      integ      = '0;
      settle_run = '0;
      stall_run  = '0;
      move_over  = 1'b0;
      last_cause = CAUSE_RUNNING;
    end else if (move_over) begin
      r.done_res  = 1'b1;
      r.end_cause = last_cause;
    end else begin
      // Deltas wrap at the encoder width; the average rounds toward minus infinity.
      dl = w.left_position - base_left;
      dr = w.right_position - base_right;
      travel = (longint'(dl) + longint'(dr)) >>> 1;
      err = longint'(cfg.target_degrees) - travel;
      mag = (err < 0) ? -err : err;

      acc = (mag > INTEGRAL_WINDOW) ? 0 : longint'(integ) + err;
      if (acc > INTEGRAL_LIMIT) acc = INTEGRAL_LIMIT;
      if (acc < -INTEGRAL_LIMIT) acc = -INTEGRAL_LIMIT;
      if (err == 0) acc = 0;
      integ = acc[INT_W-1:0];

      der = err - longint'(last_error);
      last_error = err[ERR_W-1:0];

      pid = longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * acc
          + longint'(cfg.gain_d) * der;
      quo = pid / (longint'(1) <<< GAIN_FRACTION_BITS);
      lim = (cfg.speed_limit > DRIVE_MAX) ? DRIVE_MAX : longint'(cfg.speed_limit);
      if (quo > lim) quo = lim;
      if (quo < -lim) quo = -lim;

      if (mag < longint'(cfg.settle_band)) begin
        if (settle_run < SETTLE_MAX) settle_run = settle_run + 1'b1;
      end else begin
        settle_run = '0;
      end
      if (mag > longint'(cfg.progress_band)) begin
        stall_run = '0;
      end else if (stall_run != {STALL_W{1'b1}}) begin
        stall_run = stall_run + 1'b1;
      end

      // Settling wins when both endings happen on the same sample.
      if (settle_run > 1) cause = CAUSE_SETTLED;
      else if (stall_run > cfg.timeout_ticks) cause = CAUSE_STALLED;

      if (cause != CAUSE_RUNNING) begin
        move_over   = 1'b1;
        last_cause  = cause;
        r.done_res  = 1'b1;
        r.end_cause = cause;
      end else begin
        r.drive = quo[DRIVE_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      cfg.gain_p         = 16'd18;
      cfg.gain_i         = 16'd5;
      cfg.gain_d         = 16'd102;
      cfg.speed_limit    = 7'd100;
      cfg.target_degrees = '0;
      cfg.settle_band    = '0;
      cfg.progress_band  = '0;
      cfg.timeout_ticks  = 16'd50;
      base_left  = '0;
      base_right = '0;
      last_error = '0;
      integ      = '0;
      settle_run = '0;
      stall_run  = '0;
      move_over  = 1'b1;
      last_cause = CAUSE_RUNNING;
      due_words.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:2]))
          REG_GAIN_P:         cfg.gain_p = pwdata[GAIN_W-1:0];
          REG_GAIN_I:         cfg.gain_i = pwdata[GAIN_W-1:0];
          REG_GAIN_D:         cfg.gain_d = pwdata[GAIN_W-1:0];
          REG_SPEED_LIMIT:    cfg.speed_limit = pwdata[LIMIT_W-1:0];
          REG_TARGET_DEGREES: cfg.target_degrees = pwdata[TARGET_W-1:0];
          REG_SETTLE_BAND:    cfg.settle_band = pwdata[BAND_W-1:0];
          REG_PROGRESS_BAND:  cfg.progress_band = pwdata[BAND_W-1:0];
          REG_TIMEOUT_TICKS:  cfg.timeout_ticks = pwdata[STALL_W-1:0];
          default: ;
        endcase
      end
      // Responses are compared before this edge's request is queued.
      if (rsp_valid && !rsp_stall) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got drive %0d done %0d cause %0d",
                   $time, rsp.drive, rsp.done_res, rsp.end_cause);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (rsp.drive !== want.drive) begin
            $display("%0t: drive expected %0d, got %0d", $time, want.drive, rsp.drive);
            mismatches++;
          end
          if (rsp.done_res !== want.done_res) begin
            $display("%0t: done_res expected %0d, got %0d", $time, want.done_res,
                     rsp.done_res);
            mismatches++;
          end
          if (rsp.end_cause !== want.end_cause) begin
            $display("%0t: end_cause expected %0d, got %0d", $time, want.end_cause,
                     rsp.end_cause);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) due_words.push_back(move_step(req));
    end
    words_due = due_words.size();
  end

endmodule

### verif/encoder_distance_pid_move_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_distance_pid_move_test: testbench of the encoder distance controller
// Programs the registers over the APB-style port, sends start and sample
// words shaped like real moves, and lets the checker judge every response.
// ----------------------------------------------------------------------------
module encoder_distance_pid_move_test;

  import edpm_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  int                mismatches;
  int                words_due;

  // When set, neither side inserts idle cycles.
  logic   quiet;
  // Target travel last programmed; trajectories aim at it.
  longint aim;
  int     phase_words;

  encoder_distance_pid_move dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  edpm_move_checker move_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random, about nine times in a hundred, independent of
  // whether a word is on offer, so stalls land on every pipeline phase.
  always @(negedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 9);
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("encoder_distance_pid_move_test failed");
    $finish;
  end

  // One register write: setup cycle, then access cycle. Called and returns
  // at a falling edge, with the bus idle in between writes.
  task automatic write_reg(input reg_index_t idx, input longint value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value[DATA_W-1:0];
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input longint kp, input longint ki, input longint kd,
                           input longint cap, input longint goal, input longint settle,
                           input longint progress, input longint ticks);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_SPEED_LIMIT, cap);
    write_reg(REG_TARGET_DEGREES, goal);
    write_reg(REG_SETTLE_BAND, settle);
    write_reg(REG_PROGRESS_BAND, progress);
    write_reg(REG_TIMEOUT_TICKS, ticks);
    aim = goal;
  endtask

  // Offers one word and returns at the falling edge after it was taken,
  // with valid still high: the caller either replaces the word or drops
  // valid in that same step, so valid is written once per step.
  task automatic send_word(input logic kind, input longint left, input longint right);
    req_t w;
    while (!quiet && $urandom_range(0, 99) < 9) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    w.req_type       = kind;
    w.left_position  = left[POSITION_WIDTH-1:0];
    w.right_position = right[POSITION_WIDTH-1:0];
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    phase_words++;
  endtask

  // Drops valid and waits until every response word has come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
  endtask

  // One move: a start with a random baseline, then samples whose average
  // travel closes in on the target with a little jitter. Some moves get stuck
  // at an offset from the target, which is what drives the stall timer.
  task automatic run_move(input int samples);
    longint bl, br, trav, skew, off;
    int     k;
    bit     stuck;
    bl    = longint'($urandom_range(0, 16777215));
    br    = longint'($urandom_range(0, 16777215));
    stuck = ($urandom_range(0, 3) == 0);
    off   = longint'($urandom_range(0, 150)) - 75;
    trav  = 0;
    send_word(REQ_START, bl, br);
    for (k = 0; k < samples; k++) begin
      if (stuck && k > samples / 2)
        trav = aim - off + longint'($urandom_range(0, 2)) - 1;
      else
        trav = trav + (aim - trav) / longint'($urandom_range(1, 4))
             + longint'($urandom_range(0, 6)) - 3;
      skew = longint'($urandom_range(0, 100)) - 50;
      // Occasionally the two sides disagree wildly.
      if ($urandom_range(0, 19) == 0) skew = longint'($urandom_range(0, 16777215));
      // The random extra bit on the right side makes the sum odd at times and
      // exercises the round-down of the average.
      send_word(REQ_SAMPLE, bl + trav + skew,
                br + trav - skew + longint'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int ph;
    longint goal;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    req_valid = 1'b0;
    req       = '0;
    quiet     = 1'b0;
    aim       = 0;
    phase_words = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings. A sample before any start reports finished with
    // cause zero. Extreme positions make both deltas wrap around.
    send_word(REQ_SAMPLE, 0, 0);
    send_word(REQ_START, 8388607, -8388608);
    send_word(REQ_SAMPLE, -8388608, 8388607);
    send_word(REQ_SAMPLE, 0, 0);
    send_word(REQ_SAMPLE, 8388607, 8388607);
    send_word(REQ_START, 0, 0);
    send_word(REQ_SAMPLE, 1, 0);
    send_word(REQ_SAMPLE, -1, 0);
    send_word(REQ_SAMPLE, 0, 0);
    drain();

    // All but the timeout at the top: the speed limit above 100 acts as 100,
    // and a timeout of zero ends the move on the first sample in the band.
    write_all(65535, 65535, 65535, 127, 8388607, 65535, 65535, 0);
    send_word(REQ_START, 0, 0);
    send_word(REQ_SAMPLE, 0, 0);
    send_word(REQ_SAMPLE, 5, 5);
    drain();

    // Every register at its bottom end, and a timeout that cannot fire.
    write_all(0, 0, 0, 0, -8388608, 0, 0, 65535);
    send_word(REQ_START, -8388608, -8388608);
    send_word(REQ_SAMPLE, 8388607, 8388607);
    send_word(REQ_SAMPLE, 0, 0);
    drain();

    // Settling and stalling on the same sample: settling must win, and the
    // following sample repeats the settled cause.
    write_all(18, 5, 102, 101, 10, 20, 20, 1);
    send_word(REQ_START, 0, 0);
    send_word(REQ_SAMPLE, 10, 10);
    send_word(REQ_SAMPLE, 10, 11);
    send_word(REQ_SAMPLE, 10, 10);
    drain();

    // Random settings, one per phase, each running moves until its word count
    // reaches 78, with a few stray words mixed in.
    for (ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 4) == 0)
        goal = longint'($urandom_range(0, 16777215)) - 8388608;
      else
        goal = longint'($urandom_range(0, 4000)) - 2000;
      write_all(longint'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 600)),
                longint'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 100)),
                longint'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 300)),
                longint'($urandom_range(0, 127)), goal,
                longint'($urandom_range(0, 40)),
                longint'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 200)),
                longint'(($urandom_range(0, 7) == 0) ? 32'd65535
                                                     : $urandom_range(0, 20)));
      // One phase runs with no idle cycles on either side.
      quiet = (ph == 4);
      phase_words = 0;
      while (phase_words < 78) begin
        if ($urandom_range(0, 9) == 0)
          send_word(1'($urandom_range(0, 1)), longint'($urandom), longint'($urandom));
        else
          run_move(int'($urandom_range(1, 30)));
        // Halfway through one phase, hold off until the pipeline is empty.
        if (ph == 2 && phase_words >= 44 && phase_words < 60) begin
          drain();
          phase_words = 60;
        end
      end
      drain();
      quiet = 1'b0;
    end

    // Let any stray word that should not exist show up before judging.
    repeat (12) @(negedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("encoder_distance_pid_move_test passed");
    end else begin
      $display("encoder_distance_pid_move_test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/edpm_pkg.sv
rtl/core/edpm_front.sv
rtl/core/edpm_queue.sv
rtl/core/edpm_back.sv
rtl/core/encoder_distance_pid_move.sv
verif/edpm_move_checker.sv
verif/encoder_distance_pid_move_test.sv
